@@ rtl/alae_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alae_pkg
// Shared widths, operation and status codes, sequencer states and the result
// bundle of the array list engine.
// ----------------------------------------------------------------------------
package alae_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam int FUNC_W = 3;
   localparam int POS_W  = 9;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 9;

   localparam int REQ_DATA_W = 80;   // position + value + value_high, byte padded
   localparam int RSP_DATA_W = 56;   // status + item + found + length + empty

   // operation codes
   localparam logic [FUNC_W-1:0] FN_GET       = 3'd0;
   localparam logic [FUNC_W-1:0] FN_LOCATE    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_REM_EQ    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_REM_RANGE = 3'd5;
   localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_INS_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [VAL_W-1:0] item;
      logic [LEN_W-1:0]        found;
      logic [LEN_W-1:0]        length;
   } result_type;

endpackage

@@ rtl/array_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed 32-bit entries held in a single-port-pair memory.
// ----------------------------------------------------------------------------
// Send one operation per request beat: opcode in req_tuser, position, value
// and upper bound in req_tdata. Every request yields exactly one response
// beat with status, item, found position, new length and an empty flag.
// Append, tail insert, unused opcode and rejected operations go from accept
// straight to the response; get makes a single read first. Locate, delete
// and both removes sweep the store one entry per cycle through the memory
// read port before the response; insert sweeps likewise and then makes the
// final write of the new entry. The next request is taken in the cycle after
// the response is loaded, so no new request is taken before the previous one
// is answered.
// Reset clears the length and the sequencer; memory contents stay, and only
// entries below the length are ever read.
// While rsp_tready is low the response holds in the output register; the
// engine works one more request, then holds that result and drops
// req_tready until the output register frees up.
// ----------------------------------------------------------------------------
module array_list_engine #(
   parameter int CAPACITY = alae_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [8:0] position, [40:9] value, [72:41] value_high, [79:73] zero
   input  logic [alae_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] func
   input  logic [alae_pkg::FUNC_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [33:2] item, [42:34] found_position,
   // [51:43] length, [52] is_empty, [55:53] zero
   output logic [alae_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import alae_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                    res_valid;
   logic                    res_ready;
   result_type              res;

   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [VAL_W-1:0]        mem_wr_data;
   logic                    mem_rd_en;
   logic [AW-1:0]           mem_rd_addr;
   logic [VAL_W-1:0]        mem_rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_res_ff, rsp_res_in;
   logic                    load;

   alae_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_func       (req_tuser),
      .req_position   (req_tdata[8:0]),
      .req_value      ($signed(req_tdata[40:9])),
      .req_value_high ($signed(req_tdata[72:41])),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   alae_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (VAL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: free when empty or when its beat leaves this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        (rsp_res_ff.length == '0),
                        rsp_res_ff.length,
                        rsp_res_ff.found,
                        rsp_res_ff.item,
                        rsp_res_ff.status};

endmodule

@@ rtl/alae_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alae_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alae_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/alae_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alae_ctrl
// Operation sequencer: decodes one request, sweeps the entry store one read
// per cycle, shifts or compacts entries behind the read pointer and builds
// the result.
// ----------------------------------------------------------------------------
module alae_ctrl #(
   parameter int CAPACITY = 256,
   parameter int AW       = 8,
   parameter int CW       = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [alae_pkg::FUNC_W-1:0]        req_func,
   input  logic [alae_pkg::POS_W-1:0]         req_position,
   input  logic signed [alae_pkg::VAL_W-1:0]  req_value,
   input  logic signed [alae_pkg::VAL_W-1:0]  req_value_high,
   // result
   output logic                               res_valid,
   input  logic                               res_ready,
   output alae_pkg::result_type               res,
   // store
   output logic                               mem_wr_en,
   output logic [AW-1:0]                      mem_wr_addr,
   output logic [alae_pkg::VAL_W-1:0]         mem_wr_data,
   output logic                               mem_rd_en,
   output logic [AW-1:0]                      mem_rd_addr,
   input  logic [alae_pkg::VAL_W-1:0]         mem_rd_data
);

   import alae_pkg::*;

   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   state_type               state_ff, state_in;
   logic [FUNC_W-1:0]       op_ff, op_in;
   logic [CW-1:0]           base_ff, base_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] hi_ff, hi_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           k_ff, k_in;
   logic [CW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]           lim_ff, lim_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pidx_ff, pidx_in;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic signed [VAL_W-1:0] item_ff, item_in;
   logic [CW-1:0]           found_ff, found_in;

   logic [XW-1:0]           pos_x;
   logic [XW-1:0]           cnt_x;
   logic                    pos_ok_get;
   logic                    pos_ok_ins;
   logic                    full;
   logic                    desc;
   logic                    more;
   logic                    drop;
   logic [CW-1:0]           rd_dec;
   logic signed [VAL_W-1:0] rd_s;

   assign pos_x      = XW'(req_position);
   assign cnt_x      = XW'(count_ff);
   assign pos_ok_get = (pos_x != '0) && (pos_x <= cnt_x);
   assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
   assign full       = (count_ff == CW'(CAPACITY));
   assign desc       = (op_ff == FN_INSERT);
   assign more       = desc ? (rd_ptr_ff > lim_ff) : (rd_ptr_ff < lim_ff);
   assign rd_dec     = rd_ptr_ff - 1'b1;
   assign rd_s       = $signed(mem_rd_data);

   always_comb begin
      unique if (op_ff == FN_DELETE) begin
         drop = (CW'(pidx_ff) == base_ff);
      end else if (op_ff == FN_REM_EQ) begin
         drop = (rd_s == val_ff);
      end else begin
         drop = (rd_s >= val_ff) && (rd_s <= hi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      base_ff   <= base_in;
      val_ff    <= val_in;
      hi_ff     <= hi_in;
      k_ff      <= k_in;
      rd_ptr_ff <= rd_ptr_in;
      lim_ff    <= lim_in;
      pidx_ff   <= pidx_in;
      status_ff <= status_in;
      item_ff   <= item_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      base_in     = base_ff;
      val_in      = val_ff;
      hi_in       = hi_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      rd_ptr_in   = rd_ptr_ff;
      lim_in      = lim_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      status_in   = status_ff;
      item_in     = item_ff;
      found_in    = found_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[AW-1:0];
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_ptr_ff[AW-1:0];
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_func;
               base_in   = CW'(pos_x - 1'b1);
               val_in    = req_value;
               hi_in     = req_value_high;
               status_in = STATUS_OK;
               item_in   = '0;
               found_in  = '0;
               state_in  = S_DONE;
               unique case (req_func)
                  FN_GET: begin
                     if (pos_ok_get) begin
                        rd_ptr_in = CW'(pos_x - 1'b1);
                        lim_in    = CW'(pos_x);
                        state_in  = S_SWEEP;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  FN_LOCATE: begin
                     if (count_ff != '0) begin
                        rd_ptr_in = '0;
                        lim_in    = count_ff;
                        state_in  = S_SWEEP;
                     end
                  end
                  FN_INSERT: begin
                     priority if (!pos_ok_ins) begin
                        status_in = STATUS_RANGE;
                     end else if (full) begin
                        status_in = STATUS_FULL;
                     end else if (pos_x == cnt_x + 1'b1) begin
                        // insert at the tail: nothing to shift
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_value;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        rd_ptr_in = count_ff;
                        lim_in    = CW'(pos_x - 1'b1);
                        state_in  = S_SWEEP;
                     end
                  end
                  FN_DELETE: begin
                     if (pos_ok_get) begin
                        rd_ptr_in = CW'(pos_x - 1'b1);
                        k_in      = CW'(pos_x - 1'b1);
                        lim_in    = count_ff;
                        state_in  = S_SWEEP;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  FN_REM_EQ, FN_REM_RANGE: begin
                     if (count_ff != '0) begin
                        rd_ptr_in = '0;
                        k_in      = '0;
                        lim_in    = count_ff;
                        state_in  = S_SWEEP;
                     end
                  end
                  FN_APPEND: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = req_value;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SWEEP: begin
            // issue the next read
            if (more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = desc ? rd_dec[AW-1:0] : rd_ptr_ff[AW-1:0];
               pend_in     = 1'b1;
               pidx_in     = mem_rd_addr;
               rd_ptr_in   = desc ? rd_dec : rd_ptr_ff + 1'b1;
            end
            // consume the data of the previous read
            if (pend_ff) begin
               unique case (op_ff)
                  FN_GET: begin
                     item_in  = rd_s;
                     state_in = S_DONE;
                  end
                  FN_LOCATE: begin
                     if (mem_rd_data == val_ff) begin
                        found_in = CW'(pidx_ff) + 1'b1;
                        pend_in  = 1'b0;
                        state_in = S_DONE;
                     end else if (!more) begin
                        state_in = S_DONE;
                     end
                  end
                  FN_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pidx_ff + 1'b1;
                     mem_wr_data = mem_rd_data;
                     if (!more) begin
                        state_in = S_INS_WRITE;
                     end
                  end
                  FN_DELETE, FN_REM_EQ, FN_REM_RANGE: begin
                     if (drop) begin
                        if (op_ff == FN_DELETE) begin
                           item_in = rd_s;
                        end
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = k_ff[AW-1:0];
                        mem_wr_data = mem_rd_data;
                        k_in        = k_ff + 1'b1;
                     end
                     if (!more) begin
                        count_in = drop ? k_ff : k_ff + 1'b1;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else if (!more) begin
               state_in = S_DONE;
            end
         end

         S_INS_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = base_ff[AW-1:0];
            mem_wr_data = val_ff;
            count_in    = count_ff + 1'b1;
            state_in    = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.status = status_ff;
   assign res.item   = item_ff;
   assign res.found  = LEN_W'(found_ff);
   assign res.length = LEN_W'(count_ff);

endmodule
